// File: src/rnlc_pkg.sv
package rnlc_pkg;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic [1:0] REG_NODE_ID     = 2'd0;
    localparam logic [1:0] REG_NODE_ID_LEN = 2'd1;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic       dest_port;
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       checksum_error;
    } t_out_beat;

    typedef struct packed {
        logic       is_lf;
        logic       is_cr;
        t_in_beat   beat;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
        return 5'd0;
    endfunction
endpackage

// File: src/rnlc_ram.sv
module rnlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: src/rnlc_front.sv
module rnlc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rnlc_pkg::t_in_beat i_beat,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output rnlc_pkg::t_cmd    o_q_cmd
);
    import rnlc_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= '{is_lf: (i_beat.rx_byte == CH_LF),
                                 is_cr: (i_beat.rx_byte == CH_CR), beat: i_beat};
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: src/rnlc_back.sv
module rnlc_back #(
    parameter int LINE_BYTES = 48,
    parameter int ID_BYTES   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  rnlc_pkg::t_cmd      i_q_cmd,
    input  logic [63:0]         i_node_id,
    input  logic [3:0]          i_node_id_len,
    output logic                o_valid,
    input  logic                i_stall,
    output rnlc_pkg::t_out_beat o_beat
);
    import rnlc_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);
    localparam int CW = $clog2(LINE_BYTES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_HEX   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_TEXT  = 4'd4;
    localparam logic [3:0] S_ID    = 4'd5;
    localparam logic [3:0] S_HASH  = 4'd6;
    localparam logic [3:0] S_HI    = 4'd7;
    localparam logic [3:0] S_LO    = 4'd8;
    localparam logic [3:0] S_LF    = 4'd9;
    localparam logic [3:0] S_ERR   = 4'd10;

    logic [3:0]    r_st;
    logic [CW-1:0] r_hcnt, r_rcnt, r_len, r_idx, r_pos;
    logic          r_head, r_halt, r_ring, r_found, r_hexok, r_rdv;
    logic [7:0]    r_sum, r_got, r_ob;
    logic [3:0]    r_idi;
    logic          r_ov, r_olast, r_oerr, r_oport;
    logic [7:0]    h_rd, g_rd, rd;
    logic [AW-1:0] raddr;
    logic [CW-1:0] idx_prev;
    logic          rd_hold;
    logic [4:0]    hv;
    logic          h_we, g_we;
    logic [3:0]    id_n;
    logic          out_free;
    t_in_beat      b;

    assign b = i_q_cmd.beat;
    assign out_free = !r_ov || !i_stall;
    assign id_n = (i_node_id_len > 4'(ID_BYTES)) ? 4'(ID_BYTES) : i_node_id_len;
    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;
    assign h_we = o_q_pop && b.mode && !i_q_cmd.is_lf && !i_q_cmd.is_cr
                  && (r_hcnt < CW'(LINE_BYTES));
    assign g_we = o_q_pop && !b.mode && !i_q_cmd.is_lf && !i_q_cmd.is_cr
                  && (r_rcnt < CW'(LINE_BYTES));
    assign rd_hold = (r_st == S_TEXT) && r_rdv && !out_free;
    assign idx_prev = r_idx - 1'b1;
    assign raddr = rd_hold ? idx_prev[AW-1:0] : r_idx[AW-1:0];
    assign rd = r_ring ? g_rd : h_rd;
    assign hv = hex_val(rd);
    assign o_valid = r_ov;
    assign o_beat = '{dest_port: r_oport, out_byte: r_ob,
                      last_of_run: r_olast, checksum_error: r_oerr};

    rnlc_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_host (
        .i_clk, .i_we(h_we), .i_waddr(r_hcnt[AW-1:0]), .i_wdata(b.rx_byte),
        .i_raddr(raddr), .o_rdata(h_rd));
    rnlc_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_ring (
        .i_clk, .i_we(g_we), .i_waddr(r_rcnt[AW-1:0]), .i_wdata(b.rx_byte),
        .i_raddr(raddr), .o_rdata(g_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_hcnt <= '0; r_rcnt <= '0;
            r_head <= 1'b0; r_halt <= 1'b0; r_ov <= 1'b0; r_rdv <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            r_rdv <= 1'b0;
            unique case (r_st)
                S_IDLE: if (o_q_pop) begin
                    if (h_we) r_hcnt <= r_hcnt + 1'b1;
                    if (g_we) r_rcnt <= r_rcnt + 1'b1;
                    if (b.mode) r_head <= 1'b1;
                    if (i_q_cmd.is_lf) begin
                        r_idx <= '0; r_sum <= '0; r_rdv <= 1'b0;
                        if (b.mode) begin
                            r_hcnt <= '0; r_len <= r_hcnt; r_ring <= 1'b0;
                            r_oport <= 1'b0;
                            if (!r_halt) r_st <= S_TEXT;
                        end else begin
                            r_rcnt <= '0; r_len <= r_rcnt; r_ring <= 1'b1;
                            r_found <= 1'b0;
                            if (!r_halt) r_st <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rdv) begin
                        if (rd == CH_HASH) begin
                            r_found <= 1'b1; r_pos <= r_idx - 1'b1;
                        end
                    end
                    if (r_idx < r_len) begin
                        r_idx <= r_idx + 1'b1; r_rdv <= 1'b1;
                    end else if (!r_rdv) begin
                        if (!r_found) r_st <= S_IDLE;
                        else begin
                            r_st <= S_HEX; r_idx <= r_pos + 1'b1;
                            r_got <= '0; r_hexok <= 1'b1;
                        end
                    end
                end
                S_HEX: begin
                    if (r_rdv) begin
                        if (r_hexok && hv[4])
                            r_got <= {r_got[3:0], hv[3:0]};
                        else r_hexok <= 1'b0;
                    end
                    if (r_idx < r_len) begin
                        r_idx <= r_idx + 1'b1; r_rdv <= 1'b1;
                    end else if (!r_rdv) begin
                        r_st <= S_CHK; r_idx <= '0;
                    end
                end
                S_CHK: begin
                    if (r_rdv) r_sum <= r_sum ^ rd;
                    if (r_idx < r_pos) begin
                        r_idx <= r_idx + 1'b1; r_rdv <= 1'b1;
                    end else if (!r_rdv) begin
                        r_len <= r_pos; r_idx <= '0; r_oport <= r_head;
                        if (r_sum != r_got) begin
                            r_halt <= 1'b1; r_st <= S_ERR;
                        end else begin
                            r_sum <= '0; r_st <= S_TEXT;
                        end
                    end
                end
                S_ERR: if (out_free) begin
                    r_ov <= 1'b1; r_oport <= 1'b0; r_ob <= '0;
                    r_olast <= 1'b1; r_oerr <= 1'b1; r_st <= S_IDLE;
                end
                S_TEXT: begin
                    if (r_idx < r_len && !r_rdv) begin
                        r_rdv <= 1'b1; r_idx <= r_idx + 1'b1;
                    end else if (r_rdv) begin
                        if (out_free) begin
                            r_ov <= 1'b1; r_ob <= rd; r_olast <= 1'b0;
                            r_oerr <= 1'b0; r_sum <= r_sum ^ rd;
                        end else r_rdv <= 1'b1;
                    end else if (r_idx >= r_len) begin
                        r_idi <= '0;
                        r_st <= (r_ring && r_head) ? S_HASH : S_ID;
                    end
                end
                S_ID: if (r_idi >= id_n) r_st <= S_HASH;
                else if (out_free) begin
                    r_ov <= 1'b1; r_ob <= i_node_id[{r_idi[2:0], 3'b000} +: 8];
                    r_olast <= 1'b0; r_oerr <= 1'b0;
                    r_sum <= r_sum ^ i_node_id[{r_idi[2:0], 3'b000} +: 8];
                    r_idi <= r_idi + 1'b1;
                end
                S_HASH: if (out_free) begin
                    r_ov <= 1'b1; r_ob <= CH_HASH; r_olast <= 1'b0;
                    r_oerr <= 1'b0; r_st <= S_HI;
                end
                S_HI: if (out_free) begin
                    r_ov <= 1'b1; r_ob <= hex_char(r_sum[7:4]); r_st <= S_LO;
                end
                S_LO: if (out_free) begin
                    r_ov <= 1'b1; r_ob <= hex_char(r_sum[3:0]); r_st <= S_LF;
                end
                S_LF: if (out_free) begin
                    r_ov <= 1'b1; r_ob <= CH_LF; r_olast <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/ring_node_line_checksum_relay_core.sv
// Channel | Beat              | Handshake
// in      | t_in_beat         | i_valid / o_stall
// out     | t_out_beat        | o_valid / i_stall
// cfg     | node_id, id_len   | APB, pready high
// Data bytes enter the back end's line store while it is idle. A host line end
// replays the stored line; a ring line end first makes three passes of
// the line store read port (hash scan, hex read, checksum) before replay.
// Reset is synchronous; line stores need no clearing. Output stalls hold
// the back end, and a two-entry queue lets input beats land meanwhile.
module ring_node_line_checksum_relay_core #(
    parameter int LINE_BYTES = 48,
    parameter int ID_BYTES   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rnlc_pkg::t_in_beat  i_beat,
    output logic                o_valid,
    input  logic                i_stall,
    output rnlc_pkg::t_out_beat o_beat,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import rnlc_pkg::*;

    logic [63:0] r_node_id;
    logic [3:0]  r_id_len;
    logic        q_valid, q_pop;
    t_cmd        q_cmd;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3])
            REG_NODE_ID[0]: prdata = r_node_id;
            default:        prdata = {60'd0, r_id_len};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0; r_id_len <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == 4'({REG_NODE_ID, 3'b000})) r_node_id <= pwdata;
            if (paddr == 4'({REG_NODE_ID_LEN, 3'b000})) r_id_len <= pwdata[3:0];
        end
    end

    rnlc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_beat,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd));

    rnlc_back #(.LINE_BYTES(LINE_BYTES), .ID_BYTES(ID_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_cmd(q_cmd),
        .i_node_id(r_node_id), .i_node_id_len(r_id_len),
        .o_valid, .i_stall, .o_beat);
endmodule

// File: src/rnlc_checker.sv
module rnlc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input rnlc_pkg::t_out_beat o_beat,
    input logic                pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_beat)) else $error("stall");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_beat.checksum_error |-> o_beat.last_of_run) else $error("err");
    a_err_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_beat.checksum_error |-> !o_beat.dest_port) else $error("port");
    a_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_beat.last_of_run && !o_beat.checksum_error
        |-> o_beat.out_byte == rnlc_pkg::CH_LF) else $error("lf");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready");
endmodule

bind ring_node_line_checksum_relay_core rnlc_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_beat, .pready);

// File: tb/sv/tb_ring_node_line_checksum_relay_core.sv
class relay_scoreboard;
    rnlc_pkg::t_out_beat pending_q[$];
    logic [63:0] node_id;
    logic [3:0]  node_id_len;
    logic [7:0]  host_buf[48];
    logic [7:0]  ring_buf[48];
    int          host_cnt;
    int          ring_cnt;
    bit          is_head;
    bit          halted;
    int          errors;

    function void clear();
        node_id = 0;
        node_id_len = 0;
        host_cnt = 0;
        ring_cnt = 0;
        is_head = 0;
        halted = 0;
        errors = 0;
        pending_q.delete();
    endfunction

    function void push_byte(logic port, logic [7:0] b, logic last, logic err);
        rnlc_pkg::t_out_beat r;
        r.dest_port = port;
        r.out_byte = b;
        r.last_of_run = last;
        r.checksum_error = err;
        pending_q.push_back(r);
    endfunction

    function logic [7:0] to_hex(logic [3:0] v);
        return (v < 10) ? 8'(8'h30 + v) : 8'(8'h37 + v);
    endfunction

    function void emit_frame(logic port, bit from_ring, int len, bit with_id);
        logic [7:0] sum;
        logic [7:0] c;
        int n;
        sum = 0;
        for (int i = 0; i < len; i++) begin
            c = from_ring ? ring_buf[i] : host_buf[i];
            sum ^= c;
            push_byte(port, c, 0, 0);
        end
        if (with_id) begin
            n = (node_id_len > 8) ? 8 : node_id_len;
            for (int i = 0; i < n; i++) begin
                c = node_id[8*i +: 8];
                sum ^= c;
                push_byte(port, c, 0, 0);
            end
        end
        push_byte(port, rnlc_pkg::CH_HASH, 0, 0);
        push_byte(port, to_hex(sum[7:4]), 0, 0);
        push_byte(port, to_hex(sum[3:0]), 0, 0);
        push_byte(port, rnlc_pkg::CH_LF, 1, 0);
    endfunction

    function int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function void finish_ring_line();
        int pos;
        int d;
        logic [7:0] got;
        logic [7:0] calc;
        pos = -1;
        got = 0;
        calc = 0;
        for (int i = 0; i < ring_cnt; i++)
            if (ring_buf[i] == rnlc_pkg::CH_HASH) pos = i;
        if (pos < 0) return;
        for (int i = pos + 1; i < ring_cnt; i++) begin
            d = hex_digit(ring_buf[i]);
            if (d < 0) break;
            got = {got[3:0], 4'(d)};
        end
        for (int i = 0; i < pos; i++) calc ^= ring_buf[i];
        if (calc != got) begin
            halted = 1;
            push_byte(0, 0, 1, 1);
        end else if (is_head) begin
            emit_frame(1, 1, pos, 0);
        end else begin
            emit_frame(0, 1, pos, 1);
        end
    endfunction

    function void note_input(rnlc_pkg::t_in_beat in);
        if (in.mode) begin
            is_head = 1;
            if (in.rx_byte == rnlc_pkg::CH_LF) begin
                if (!halted) emit_frame(0, 0, host_cnt, 1);
                host_cnt = 0;
            end else if (in.rx_byte != rnlc_pkg::CH_CR && host_cnt < 48) begin
                host_buf[host_cnt] = in.rx_byte;
                host_cnt++;
            end
        end else begin
            if (in.rx_byte == rnlc_pkg::CH_LF) begin
                if (!halted) finish_ring_line();
                ring_cnt = 0;
            end else if (in.rx_byte != rnlc_pkg::CH_CR && ring_cnt < 48) begin
                ring_buf[ring_cnt] = in.rx_byte;
                ring_cnt++;
            end
        end
    endfunction

    function void check_output(rnlc_pkg::t_out_beat got);
        rnlc_pkg::t_out_beat want;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (got.dest_port !== want.dest_port) begin
            $display("%0t: dest_port exp %h got %h", $time, want.dest_port, got.dest_port);
            errors++;
        end
        if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte exp %h got %h", $time, want.out_byte, got.out_byte);
            errors++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run exp %h got %h", $time, want.last_of_run,
                     got.last_of_run);
            errors++;
        end
        if (got.checksum_error !== want.checksum_error) begin
            $display("%0t: checksum_error exp %h got %h", $time, want.checksum_error,
                     got.checksum_error);
            errors++;
        end
    endfunction
endclass

module tb_ring_node_line_checksum_relay_core;
    import rnlc_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    t_in_beat    i_beat = '0;
    logic        o_valid;
    logic        i_stall = 1;
    t_out_beat   o_beat;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic        pready;

    relay_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_long = 0;
    int  sent = 0;

    ring_node_line_checksum_relay_core DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_input(i_beat);
        if (i_rst_n && o_valid && !i_stall) sb.check_output(o_beat);
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : receiver
        int w;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_stall <= 1;
                repeat (300) @(negedge i_clk);
                hold_long = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                i_stall <= 1;
                repeat (w - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_stall <= 0;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 4'(idx * 8);
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_NODE_ID) sb.node_id = val;
        else sb.node_id_len = val[3:0];
    endtask

    task automatic send_byte(logic mode, logic [7:0] b, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 5) : 0;
        if (w > 0) begin
            i_valid <= 0;
            repeat (w) @(negedge i_clk);
        end
        i_valid <= 1;
        i_beat <= '{mode: mode, rx_byte: b};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 0;
        @(negedge i_clk);
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic byte hex_of(logic [3:0] v, bit lower);
        if (v < 10) return 8'h30 + v;
        return (lower ? 8'h57 : 8'h37) + v;
    endfunction

    task automatic send_ring_line(int len, bit good, bit gaps);
        logic [7:0] sum;
        logic [7:0] c;
        int shape;
        sum = 0;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < len; i++) begin
            c = $urandom_range(0, 255);
            if (c == CH_LF || c == CH_HASH) c = 8'h41;
            if ($urandom_range(0, 15) == 0) c = CH_CR;
            else sum ^= c;
            send_byte(0, c, gaps);
        end
        if (!good) sum ^= 8'($urandom_range(1, 255));
        send_byte(0, CH_HASH, gaps);
        if (shape == 0) begin
            send_byte(0, hex_of(4'($urandom), 0), gaps);
            send_byte(0, hex_of(sum[7:4], 1), gaps);
            send_byte(0, hex_of(sum[3:0], 0), gaps);
            send_byte(0, "z", gaps);
        end else if (shape == 1 && sum == 0) begin
        end else begin
            send_byte(0, hex_of(sum[7:4], shape[0]), gaps);
            send_byte(0, hex_of(sum[3:0], shape[1]), gaps);
        end
        send_byte(0, CH_LF, gaps);
    endtask

    task automatic send_host_line(int len, bit gaps);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_byte(1, CH_CR, gaps);
            else send_byte(1, 8'($urandom_range(0, 255)) == CH_LF ? 8'h00
                                                                  : 8'($urandom), gaps);
        end
        send_byte(1, CH_LF, gaps);
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;

        write_reg(REG_NODE_ID, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_NODE_ID_LEN, 4'd0);
        send_ring_line(3, 1, 0);
        send_ring_line(0, 1, 0);
        send_byte(0, 8'h31, 0);
        send_byte(0, CH_LF, 0);
        drain();
        write_reg(REG_NODE_ID_LEN, 4'd15);
        write_reg(REG_NODE_ID, 64'h0000_4400_FF80_7F01);
        send_ring_line(2, 1, 0);
        send_byte(1, 8'h00, 0);
        send_byte(1, 8'hFF, 0);
        send_byte(1, CH_CR, 0);
        send_byte(1, CH_LF, 0);
        send_ring_line(1, 1, 0);
        drain();

        write_reg(REG_NODE_ID_LEN, 4'd3);
        hold_long = 1;
        send_host_line(55, 1);
        send_ring_line(52, 1, 1);
        drain();

        while (sent < 400) begin
            case ($urandom_range(0, 9))
                0: send_host_line($urandom_range(0, 12), 1);
                1: begin
                    for (int i = 0; i < $urandom_range(1, 6); i++)
                        send_byte(1'($urandom_range(0, 1)), 8'($urandom), 1);
                    send_byte(0, CH_LF, 1);
                end
                2: begin
                    drain();
                    write_reg(REG_NODE_ID, {$urandom, $urandom});
                    write_reg(REG_NODE_ID_LEN, 4'($urandom_range(0, 15)));
                end
                default: send_ring_line($urandom_range(0, 10), $urandom_range(0, 20) != 0, 1);
            endcase
        end
        send_ring_line(4, 0, 1);
        send_host_line(3, 1);
        send_ring_line(4, 1, 1);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
src/rnlc_pkg.sv
src/rnlc_ram.sv
src/rnlc_front.sv
src/rnlc_back.sv
src/ring_node_line_checksum_relay_core.sv
src/rnlc_checker.sv
tb/sv/tb_ring_node_line_checksum_relay_core.sv
